// ===== rtl/core/rgb_strip_effect_engine_defines.svh =====
// Assertion macros shared by the strip effect engine modules.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef RGB_STRIP_EFFECT_ENGINE_DEFINES_SVH
`define RGB_STRIP_EFFECT_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RSEE_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled during reset
`define RSEE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/core/rsee_pkg.sv =====
// Package for the RGB strip effect engine: mode codes, controller/datapath
// command and status types, LFSR, color wheel and fixed-point helpers. No dependencies.
package rsee_pkg;

   typedef enum logic [3:0] {
      MODE_WHITE     = 4'd0,
      MODE_POT_WHEEL = 4'd1,
      MODE_SWEEP     = 4'd2,
      MODE_FLOW      = 4'd3,
      MODE_GRADIENT  = 4'd4,
      MODE_CHASE     = 4'd5,
      MODE_METEOR    = 4'd6,
      MODE_BREATH    = 4'd7,
      MODE_RANDOM    = 4'd8
   } mode_type;

   localparam logic [3:0]  MODE_MAX      = 4'd8;
   localparam logic [15:0] RANDOM_SEED   = 16'hACE1;
   localparam logic [15:0] RANDOM_TAPS   = 16'hB400;
   // x/100 as (x*5243)>>19, exact for x below 25600
   localparam int          DIV100_RECIP  = 5243;
   localparam int          DIV100_SHIFT  = 19;
   localparam int          RATIO_NUM     = 74;
   localparam int          FALL_BASE     = 25500;
   localparam logic [9:0]  THIRD_ONE     = 10'd342;
   localparam logic [9:0]  THIRD_TWO     = 10'd684;
   localparam logic [9:0]  WHEEL_LAST    = 10'd767;
   localparam logic [9:0]  FLOW_STEP     = 10'd8;
   localparam logic [7:0]  CHASE_PERIOD  = 8'd9;
   localparam logic [7:0]  METEOR_PERIOD = 8'd49;
   localparam logic [7:0]  METEOR_FADE   = 8'd16;
   localparam logic [7:0]  BREATH_WRAP   = 8'd254;
   localparam logic [7:0]  BREATH_TURN   = 8'd127;
   localparam logic [7:0]  BREATH_STEP   = 8'd2;

   typedef struct packed {
      logic accept;
      logic read_head0;
      logic read_head1;
      logic prep_a;
      logic prep_b;
      logic prep_c;
      logic read_pix;
      logic write_pix;
   } rsee_cmd_type;

   typedef struct packed {
      logic last;
      logic out_free;
   } rsee_sts_type;

   // Galois LFSR step, returns the new state
   function automatic logic [15:0] lfsr_next(input logic [15:0] s);
      logic [15:0] n;
      n = {1'b0, s[15:1]};
      if (s[0]) n = n ^ RANDOM_TAPS;
      return n;
   endfunction

   // Color wheel, packed {red, green, blue}
   function automatic logic [23:0] wheel_color(input logic [9:0] c);
      logic [9:0] cc;
      cc = (c > WHEEL_LAST) ? WHEEL_LAST : c;
      if (cc < 10'd256)      return {~cc[7:0], cc[7:0], 8'h00};
      else if (cc < 10'd512) return {8'h00, ~cc[7:0], cc[7:0]};
      else                   return {cc[7:0], 8'h00, ~cc[7:0]};
   endfunction

   // Flowing-wheel preset of one pixel, {red, green, blue}
   function automatic logic [23:0] preset_pixel(input logic [5:0] i);
      logic [7:0] g;
      g = {i[4:0], 3'b000};
      return {8'd255 - g, g, 8'h00};
   endfunction

   // floor(255/len) for gradient lengths 5..15
   function automatic logic [5:0] grad_step(input logic [3:0] len);
      case (len)
         4'd5:    return 6'd51;
         4'd6:    return 6'd42;
         4'd7:    return 6'd36;
         4'd8:    return 6'd31;
         4'd9:    return 6'd28;
         4'd10:   return 6'd25;
         4'd11:   return 6'd23;
         4'd12:   return 6'd21;
         4'd13:   return 6'd19;
         4'd14:   return 6'd18;
         4'd15:   return 6'd17;
         default: return 6'd51;
      endcase
   endfunction

endpackage

// ===== rtl/core/rsee_ctrl.sv =====
// Frame sequencer of the strip effect engine: head prefetch, frame update
// steps, then a read/write walk per pixel. Depends on rsee_pkg.
module rsee_ctrl
   import rsee_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  rsee_sts_type sts,
   output rsee_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_HEAD0, ST_HEAD1, ST_PREP_A, ST_PREP_B, ST_PREP_C, ST_READ, ST_WRITE
   } state_type;

   state_type state_ff;

   // commands decoded from state
   always_comb begin
      cmd            = '0;
      cmd.accept     = (state_ff == ST_IDLE) && req_valid;
      cmd.read_head0 = (state_ff == ST_HEAD0);
      cmd.read_head1 = (state_ff == ST_HEAD1);
      cmd.prep_a     = (state_ff == ST_PREP_A);
      cmd.prep_b     = (state_ff == ST_PREP_B);
      cmd.prep_c     = (state_ff == ST_PREP_C);
      cmd.read_pix   = (state_ff == ST_READ);
      cmd.write_pix  = (state_ff == ST_WRITE) && sts.out_free;
   end

   assign req_stall = (state_ff != ST_IDLE);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE:   if (req_valid) state_ff <= ST_HEAD0;
            ST_HEAD0:  state_ff <= ST_HEAD1;
            ST_HEAD1:  state_ff <= ST_PREP_A;
            ST_PREP_A: state_ff <= ST_PREP_B;
            ST_PREP_B: state_ff <= ST_PREP_C;
            ST_PREP_C: state_ff <= ST_READ;
            ST_READ:   state_ff <= ST_WRITE;
            ST_WRITE: begin
               if (sts.out_free) state_ff <= sts.last ? ST_IDLE : ST_READ;
            end
            default:   state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/core/rsee_datapath.sv =====
// Datapath of the strip effect engine: strip memory with valid bits, effect
// state, per-frame update math and the output register. Depends on rsee_pkg.
`include "rgb_strip_effect_engine_defines.svh"
module rsee_datapath
   import rsee_pkg::*;
#(
   parameter int PIXEL_COUNT = 50
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic [3:0]   csr_write_data,
   input  logic [9:0]   req_pot_level,
   input  rsee_cmd_type cmd,
   output rsee_sts_type sts,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [5:0]   rsp_pixel_index,
   output logic [7:0]   rsp_green_level,
   output logic [7:0]   rsp_red_level,
   output logic [7:0]   rsp_blue_level,
   output logic         rsp_last_pixel
);

   localparam int IDX_W = $clog2(PIXEL_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIXEL_COUNT - 1);

   // strip memory, {red, green, blue}
   logic [23:0]            mem [PIXEL_COUNT];
   logic [PIXEL_COUNT-1:0] valid_ff;
   logic                   preset_ff;

   mode_type   mode_ff, mode_in;
   logic [9:0] wheel_ff, wheel_in;
   logic [7:0] phase_ff, phase_in;
   logic [7:0] bcount_ff, bcount_in;
   logic [7:0] bchan_ff, bchan_in;
   logic [15:0] rand_ff, rand_in;
   logic       clear_store;

   logic [9:0]  pot_ff;
   logic [IDX_W-1:0] pix_ff;
   logic [IDX_W-1:0] rd_addr;
   logic [23:0] rd_mem_ff, rd_fallback_ff, old_pix;
   logic        rd_hit_ff;
   logic [23:0] old0_ff, prev_ff;
   logic [23:0] pre0_ff, pre0_in;
   logic [23:0] fill_ff, fill_in;
   logic        up_ff, up_in;
   logic [3:0]  len_ff;
   logic [5:0]  step_ff;

   logic [8:0]  third_pos;
   logic [14:0] prod74_ff;
   logic [22:0] potq_prod_ff;
   logic [27:0] rise_prod_ff, fall_prod_ff;
   logic [7:0]  rise, fall;
   logic [3:0]  len_in;

   logic [23:0] new_pix;
   logic        rsp_valid_ff;

   // read address select
   always_comb begin
      if (cmd.read_head0)      rd_addr = '0;
      else if (cmd.read_head1) rd_addr = IDX_W'(1);
      else                     rd_addr = pix_ff;
   end

   // registered read, unwritten entries read as zero or the flow preset
   always_ff @(posedge clock) begin
      if (cmd.read_head0 || cmd.read_head1 || cmd.read_pix) begin
         rd_mem_ff      <= mem[rd_addr];
         rd_hit_ff      <= valid_ff[rd_addr];
         rd_fallback_ff <= preset_ff ? preset_pixel(6'(rd_addr)) : 24'h0;
      end
      if (cmd.write_pix) mem[pix_ff] <= new_pix;
   end

   assign old_pix = rd_hit_ff ? rd_mem_ff : rd_fallback_ff;

   // valid bits and preset flag
   assign clear_store = csr_write_enable;
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         preset_ff <= 1'b0;
      end else if (clear_store) begin
         valid_ff  <= '0;
         preset_ff <= (mode_in == MODE_FLOW);
      end else if (cmd.write_pix) begin
         valid_ff[pix_ff] <= 1'b1;
      end
   end

   // fixed-point math for the pot wheel and gradient length
   always_comb begin
      if (pot_ff < THIRD_ONE)      third_pos = 9'(pot_ff);
      else if (pot_ff < THIRD_TWO) third_pos = 9'(pot_ff - THIRD_ONE);
      else                         third_pos = 9'(pot_ff - THIRD_TWO);
   end

   always_ff @(posedge clock) begin
      if (cmd.prep_a) begin
         prod74_ff    <= 15'(15'(third_pos) * 15'(RATIO_NUM));
         potq_prod_ff <= 23'(23'(pot_ff) * 23'(DIV100_RECIP));
      end
      if (cmd.prep_b) begin
         rise_prod_ff <= 28'(28'(prod74_ff) * 28'(DIV100_RECIP));
         fall_prod_ff <= 28'(28'(15'(FALL_BASE) - prod74_ff) * 28'(DIV100_RECIP));
      end
   end

   assign rise   = rise_prod_ff[DIV100_SHIFT +: 8];
   assign fall   = fall_prod_ff[DIV100_SHIFT +: 8];
   assign len_in = potq_prod_ff[DIV100_SHIFT +: 4] + 4'd5;

   // effect state next values: frame step, mode 8 draws, register write
   always_comb begin
      logic [15:0] d0, d1, d2;
      logic [9:0]  p;
      logic [7:0]  cnt, ch;
      d0 = lfsr_next(rand_ff);
      d1 = lfsr_next(d0);
      d2 = lfsr_next(d1);
      p  = '0;
      cnt = bcount_ff;
      ch  = bchan_ff;
      mode_in   = mode_ff;
      wheel_in  = wheel_ff;
      phase_in  = phase_ff;
      bcount_in = bcount_ff;
      bchan_in  = bchan_ff;
      rand_in   = rand_ff;
      pre0_in   = pre0_ff;
      fill_in   = fill_ff;
      up_in     = up_ff;
      if (cmd.prep_c) begin
         case (mode_ff)
            MODE_POT_WHEEL: begin
               if (pot_ff < THIRD_ONE)      fill_in = {fall, rise, 8'h00};
               else if (pot_ff < THIRD_TWO) fill_in = {8'h00, fall, rise};
               else                         fill_in = {rise, 8'h00, fall};
            end
            MODE_SWEEP: begin
               p        = (wheel_ff > WHEEL_LAST) ? 10'd0 : wheel_ff;
               fill_in  = wheel_color(p);
               wheel_in = (p >= WHEEL_LAST) ? 10'd0 : p + 10'd1;
            end
            MODE_FLOW: begin
               p        = wheel_ff + FLOW_STEP;
               p        = (p > WHEEL_LAST) ? 10'd0 : p;
               pre0_in  = wheel_color(p);
               wheel_in = p;
            end
            MODE_CHASE: begin
               if (phase_ff == 8'd0) begin
                  pre0_in = {d0[7:0], d1[7:0], d2[7:0]};
                  rand_in = d2;
               end else begin
                  pre0_in = old_pix;
               end
               phase_in = (phase_ff == CHASE_PERIOD) ? 8'd0 : phase_ff + 8'd1;
            end
            MODE_METEOR: begin
               if (phase_ff == 8'd0) begin
                  pre0_in = {d0[7:0], d1[7:0], d2[7:0]};
                  rand_in = d2;
               end else if (phase_ff < METEOR_FADE) begin
                  if (!phase_ff[0])
                     pre0_in = {1'b0, old0_ff[23:17], 1'b0, old0_ff[15:9],
                                1'b0, old0_ff[7:1]};
                  else
                     pre0_in = old0_ff;
               end else begin
                  pre0_in = 24'h0;
               end
               phase_in = (phase_ff == METEOR_PERIOD) ? 8'd0 : phase_ff + 8'd1;
            end
            MODE_BREATH: begin
               if (cnt >= BREATH_WRAP) begin
                  ch      = d0[7:0];
                  rand_in = d0;
                  cnt     = 8'd0;
               end
               if (ch[2:0] == 3'b000) ch = 8'd1;
               up_in     = (cnt < BREATH_TURN);
               bchan_in  = ch;
               bcount_in = cnt + 8'd1;
            end
            MODE_GRADIENT: fill_in = fill_ff;
            MODE_RANDOM:   fill_in = fill_ff;
            default:       fill_in = {3{pot_ff[9:2]}};
         endcase
      end
      if (cmd.write_pix && (mode_ff == MODE_RANDOM)) rand_in = d0;
      // register write restarts the effect
      if (csr_write_enable) begin
         mode_in   = (csr_write_data > MODE_MAX) ? MODE_WHITE : mode_type'(csr_write_data);
         wheel_in  = '0;
         phase_in  = '0;
         bcount_in = '0;
         if (mode_in == MODE_BREATH) begin
            bchan_in = d0[7:0];
            rand_in  = d0;
         end
      end
   end

   // effect state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_WHITE;
         wheel_ff  <= '0;
         phase_ff  <= '0;
         bcount_ff <= '0;
         rand_ff   <= lfsr_next(RANDOM_SEED);
         bchan_ff  <= 8'(lfsr_next(RANDOM_SEED));
      end else begin
         mode_ff   <= mode_in;
         wheel_ff  <= wheel_in;
         phase_ff  <= phase_in;
         bcount_ff <= bcount_in;
         rand_ff   <= rand_in;
         bchan_ff  <= bchan_in;
      end
   end

   // frame working registers
   always_ff @(posedge clock) begin
      if (cmd.accept) pot_ff <= req_pot_level;
      if (cmd.read_head1) old0_ff <= old_pix;
      if (cmd.prep_c) begin
         pre0_ff <= pre0_in;
         fill_ff <= fill_in;
         up_ff   <= up_in;
         len_ff  <= len_in;
         step_ff <= grad_step(len_in);
      end
      if (cmd.write_pix) prev_ff <= old_pix;
   end

   // pixel counter
   always_ff @(posedge clock) begin
      if (reset) pix_ff <= '0;
      else if (cmd.accept) pix_ff <= '0;
      else if (cmd.write_pix && (pix_ff != LAST_IDX)) pix_ff <= pix_ff + IDX_W'(1);
   end

   // new value of the current pixel
   always_comb begin
      logic [IDX_W-1:0] k;
      logic [11:0]      gj, gk;
      logic [7:0]       r, g, b, c8;
      logic [15:0]      c;
      k  = LAST_IDX - pix_ff;
      gj = 12'(step_ff) * 12'(pix_ff);
      gk = 12'(step_ff) * 12'(k);
      {r, g, b} = old_pix;
      c  = lfsr_next(rand_ff);
      c8 = 8'h0;
      case (mode_ff)
         MODE_FLOW, MODE_CHASE, MODE_METEOR:
            new_pix = (pix_ff <= IDX_W'(1)) ? pre0_ff : prev_ff;
         MODE_GRADIENT: begin
            if (6'(pix_ff) < 6'(len_ff)) begin
               c8      = 8'd255 - gj[7:0];
               new_pix = {8'h00, 8'h00, c8};
            end else if (6'(k) < 6'(len_ff)) begin
               c8      = 8'd255 - gk[7:0];
               new_pix = {c8, 8'h00, c8};
            end else begin
               new_pix = 24'h0;
            end
         end
         MODE_BREATH: begin
            if (bchan_ff[0]) r = up_ff ? r + BREATH_STEP : r - BREATH_STEP;
            if (bchan_ff[1]) g = up_ff ? g + BREATH_STEP : g - BREATH_STEP;
            if (bchan_ff[2]) b = up_ff ? b + BREATH_STEP : b - BREATH_STEP;
            new_pix = {r, g, b};
         end
         MODE_RANDOM: new_pix = {c[11:4], c[9:2], c[7:0]};
         default:     new_pix = fill_ff;
      endcase
   end

   // output register
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;
   assign sts.last     = (pix_ff == LAST_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.write_pix) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_pix) begin
         rsp_pixel_index <= 6'(pix_ff);
         rsp_red_level   <= new_pix[23:16];
         rsp_green_level <= new_pix[15:8];
         rsp_blue_level  <= new_pix[7:0];
         rsp_last_pixel  <= (pix_ff == LAST_IDX);
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `RSEE_ASSERT_IMPLY(a_write_needs_slot, clock, reset, cmd.write_pix, !rsp_valid_ff || !rsp_stall)
   `RSEE_ASSERT_IMPLY(a_last_at_end, clock, reset, rsp_valid_ff && rsp_last_pixel, rsp_pixel_index == 6'(LAST_IDX))
   `RSEE_ASSERT_NEXT(a_breath_has_channel, clock, reset, cmd.prep_c && (mode_ff == MODE_BREATH), bchan_ff[2:0] != 3'b000)

endmodule

// ===== rtl/core/rgb_strip_effect_engine.sv =====
// Top level of the RGB strip effect engine: sequencer plus datapath.
// Depends on rsee_pkg, rsee_ctrl and rsee_datapath.
//
// Use: each item on the req_ channel is one frame tick carrying a 10-bit
// pot sample. The block updates its strip store under the current effect and
// sends PIXEL_COUNT items on the rsp_ channel, pixel 0 first, the final one
// with rsp_last_pixel set. csr_write_enable/csr_write_data select the effect
// (codes 9..15 act as 0) and restart it; write only while the block is idle.
// Flow: once a frame is taken, the sequencer reads head pixels 0 and 1,
// runs the update steps prep_a, prep_b and prep_c, then walks the pixels,
// each as a memory read, then update and write back via the single-port strip store.
// One frame is worked on at a time; req_stall is high while it runs.
// A stalled result holds in the output register and the pixel walk waits.
// Reset (synchronous) clears the store to dark via valid bits, so no
// clearing pass is needed, zeroes the counters, seeds the random generator
// and selects the white-level effect.
module rgb_strip_effect_engine
   import rsee_pkg::*;
#(
   parameter int PIXEL_COUNT = 50
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [3:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [9:0] req_pot_level,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [5:0] rsp_pixel_index,
   output logic [7:0] rsp_green_level,
   output logic [7:0] rsp_red_level,
   output logic [7:0] rsp_blue_level,
   output logic       rsp_last_pixel
);

   rsee_cmd_type cmd;
   rsee_sts_type sts;

   rsee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rsee_datapath #(
      .PIXEL_COUNT (PIXEL_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_pot_level    (req_pot_level),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_index  (rsp_pixel_index),
      .rsp_green_level  (rsp_green_level),
      .rsp_red_level    (rsp_red_level),
      .rsp_blue_level   (rsp_blue_level),
      .rsp_last_pixel   (rsp_last_pixel)
   );

endmodule
